@@ rtl/mi3_pkg.sv @@
`default_nettype none
package mi3_pkg;

  // element formats
  localparam int IN_W     = 16;
  localparam int IN_FRAC  = 8;
  localparam int OUT_W    = 32;
  localparam int OUT_FRAC = 16;
  localparam int N_EL     = 9;

  // intermediate widths, all exact
  localparam int PROD_W  = 2 * IN_W;
  localparam int COF_W   = PROD_W + 1;
  localparam int DPROD_W = IN_W + COF_W;
  localparam int DET_W   = DPROD_W + 2;
  localparam int SH      = IN_FRAC + OUT_FRAC;
  localparam int Q_W     = OUT_W + 1;
  localparam int REM_W   = DET_W + Q_W;

  // cofactor k = e[p]*e[q] - e[r]*e[s], element index = row + 3*column
  localparam logic [3:0] COF_IDX [N_EL][4] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd7, 4'd2, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd4, 4'd2},
    '{4'd6, 4'd5, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
  };

  // word passed from front to back
  typedef struct packed {
    logic [N_EL-1:0][COF_W-1:0] cof;
    logic                       det_neg;
    logic [DET_W-1:0]           dmag;
    logic                       singular;
  } qitem_t;

  // one divider stage, nine lanes
  typedef struct packed {
    logic [N_EL-1:0][REM_W-1:0] rem;
    logic [N_EL-1:0][Q_W-1:0]   quo;
    logic [N_EL-1:0]            neg;
    logic [N_EL-1:0]            big;
    logic [DET_W-1:0]           dmag;
    logic                       singular;
  } dstage_t;

  // result word
  typedef struct packed {
    logic [N_EL-1:0][OUT_W-1:0] inv;
    logic                       singular;
    logic                       saturated;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/mi3_front.sv @@
`default_nettype none
module mi3_front (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_push,
  input  wire logic [mi3_pkg::N_EL-1:0][mi3_pkg::IN_W-1:0] in_elem,
  output logic                                           in_full,
  output logic                                           q_push,
  output mi3_pkg::qitem_t                                q_item,
  input  wire logic                                      q_full
);

  logic [3:0] v_r;
  logic       en;

  logic signed [mi3_pkg::PROD_W-1:0]  pa [mi3_pkg::N_EL];
  logic signed [mi3_pkg::PROD_W-1:0]  pb [mi3_pkg::N_EL];
  logic signed [mi3_pkg::PROD_W-1:0]  pa_r [mi3_pkg::N_EL];
  logic signed [mi3_pkg::PROD_W-1:0]  pb_r [mi3_pkg::N_EL];
  logic signed [mi3_pkg::IN_W-1:0]    ed1_r [3];
  logic signed [mi3_pkg::IN_W-1:0]    ed2_r [3];
  logic signed [mi3_pkg::COF_W-1:0]   cof2_r [mi3_pkg::N_EL];
  logic signed [mi3_pkg::COF_W-1:0]   cof3_r [mi3_pkg::N_EL];
  logic signed [mi3_pkg::COF_W-1:0]   cof4_r [mi3_pkg::N_EL];
  logic signed [mi3_pkg::DPROD_W-1:0] dp3_r [3];
  logic signed [mi3_pkg::DET_W-1:0]   det4_r;

  // whole front advances unless the last stage is blocked
  assign en      = !(v_r[3] && q_full);
  assign in_full = !en;
  assign q_push  = v_r[3] && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_push};
    end
  end

  // cofactor products
  always_comb begin
    for (int k = 0; k < mi3_pkg::N_EL; k++) begin
      pa[k] = $signed(in_elem[mi3_pkg::COF_IDX[k][0]]) * $signed(in_elem[mi3_pkg::COF_IDX[k][1]]);
      pb[k] = $signed(in_elem[mi3_pkg::COF_IDX[k][2]]) * $signed(in_elem[mi3_pkg::COF_IDX[k][3]]);
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mi3_pkg::N_EL; k++) begin
        pa_r[k]   <= pa[k];
        pb_r[k]   <= pb[k];
        cof2_r[k] <= mi3_pkg::COF_W'(pa_r[k]) - mi3_pkg::COF_W'(pb_r[k]);
        cof3_r[k] <= cof2_r[k];
        cof4_r[k] <= cof3_r[k];
      end
      for (int j = 0; j < 3; j++) begin
        ed1_r[j] <= $signed(in_elem[3*j]);
        ed2_r[j] <= ed1_r[j];
        dp3_r[j] <= ed2_r[j] * cof2_r[j];
      end
      det4_r <= mi3_pkg::DET_W'(dp3_r[0]) + mi3_pkg::DET_W'(dp3_r[1])
              + mi3_pkg::DET_W'(dp3_r[2]);
    end
  end

  // classify: sign, magnitude, zero determinant
  always_comb begin
    for (int k = 0; k < mi3_pkg::N_EL; k++) begin
      q_item.cof[k] = cof4_r[k];
    end
    q_item.det_neg  = det4_r[mi3_pkg::DET_W-1];
    q_item.dmag     = det4_r[mi3_pkg::DET_W-1] ? mi3_pkg::DET_W'(-det4_r)
                                                : mi3_pkg::DET_W'(det4_r);
    q_item.singular = (det4_r == '0);
  end

endmodule
`default_nettype wire

@@ rtl/mi3_queue.sv @@
`default_nettype none
module mi3_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mi3_pkg::qitem_t wr_item,
  output logic                 full,
  input  wire logic            pop,
  output mi3_pkg::qitem_t      rd_item,
  output logic                 empty
);

  mi3_pkg::qitem_t ent_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = ent_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= wr_item;
  end

endmodule
`default_nettype wire

@@ rtl/mi3_back.sv @@
`default_nettype none
module mi3_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire mi3_pkg::qitem_t q_item,
  output logic                 q_pop,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output mi3_pkg::result_t     out_res
);

  localparam int QW = mi3_pkg::Q_W;
  localparam logic [QW-1:0] HALF = QW'(1) << (mi3_pkg::OUT_W - 1);
  localparam logic [QW-1:0] MAXP = HALF - QW'(1);

  logic              en;
  logic              a_v_r;
  mi3_pkg::qitem_t   a_r;
  mi3_pkg::dstage_t  init;
  logic [QW:0]       d_v_r;
  mi3_pkg::dstage_t  d_r [QW+1];
  mi3_pkg::dstage_t  d_nxt [QW];
  mi3_pkg::result_t  fin;
  mi3_pkg::result_t  ob_r [2];
  logic              ob_wp_r, ob_rp_r;
  logic [1:0]        ob_cnt_r;
  logic              ob_full, ob_push, ob_pop;

  // back pipeline stalls only when its last word cannot enter the output buffer
  assign ob_full = (ob_cnt_r == 2'd2);
  assign en      = !(d_v_r[QW] && ob_full);
  assign q_pop   = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      d_v_r <= '0;
    end else if (en) begin
      a_v_r <= !q_empty;
      d_v_r <= {d_v_r[QW-1:0], a_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en && !q_empty) a_r <= q_item;
  end

  // numerator with rounding term, overflow test against dmag * 2^QW
  always_comb begin
    logic [mi3_pkg::COF_W-1:0] mag;
    logic [mi3_pkg::REM_W-1:0] num;
    init.dmag     = a_r.dmag;
    init.singular = a_r.singular;
    for (int k = 0; k < mi3_pkg::N_EL; k++) begin
      mag = a_r.cof[k][mi3_pkg::COF_W-1] ? -a_r.cof[k] : a_r.cof[k];
      num = (mi3_pkg::REM_W'(mag) << mi3_pkg::SH) + mi3_pkg::REM_W'(a_r.dmag >> 1);
      init.rem[k] = num;
      init.quo[k] = '0;
      init.neg[k] = a_r.cof[k][mi3_pkg::COF_W-1] ^ a_r.det_neg;
      init.big[k] = (num >= (mi3_pkg::REM_W'(a_r.dmag) << QW));
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r[0] <= init;
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar s = 0; s < QW; s++) begin : gen_div
    localparam int B = QW - 1 - s;
    always_comb begin
      logic [mi3_pkg::REM_W-1:0] dsh;
      d_nxt[s] = d_r[s];
      dsh      = mi3_pkg::REM_W'(d_r[s].dmag) << B;
      for (int k = 0; k < mi3_pkg::N_EL; k++) begin
        if (d_r[s].rem[k] >= dsh) begin
          d_nxt[s].rem[k]    = d_r[s].rem[k] - dsh;
          d_nxt[s].quo[k][B] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) d_r[s+1] <= d_nxt[s];
    end
  end

  // sign, saturation, singular override
  always_comb begin
    logic [QW-1:0] q;
    logic          clip;
    fin.singular  = d_r[QW].singular;
    fin.saturated = 1'b0;
    for (int k = 0; k < mi3_pkg::N_EL; k++) begin
      q = d_r[QW].quo[k];
      if (d_r[QW].neg[k]) begin
        clip = d_r[QW].big[k] || (q > HALF);
        fin.inv[k] = clip ? mi3_pkg::OUT_W'(HALF) : mi3_pkg::OUT_W'(-q);
      end else begin
        clip = d_r[QW].big[k] || (q > MAXP);
        fin.inv[k] = clip ? mi3_pkg::OUT_W'(MAXP) : mi3_pkg::OUT_W'(q);
      end
      if (clip) fin.saturated = 1'b1;
    end
    if (d_r[QW].singular) begin
      fin.inv       = '0;
      fin.saturated = 1'b0;
    end
  end

  // two-word output buffer
  assign ob_push   = d_v_r[QW] && en;
  assign out_empty = (ob_cnt_r == 2'd0);
  assign ob_pop    = out_pop && !out_empty;
  assign out_res   = ob_r[ob_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wp_r  <= 1'b0;
      ob_rp_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      if (ob_push) ob_wp_r <= !ob_wp_r;
      if (ob_pop)  ob_rp_r <= !ob_rp_r;
      ob_cnt_r <= ob_cnt_r + 2'(ob_push) - 2'(ob_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) ob_r[ob_wp_r] <= fin;
  end

endmodule
`default_nettype wire

@@ rtl/matrix3_inverse.sv @@
`default_nettype none
// channel | direction | handshake      | word
// input   | in        | push / full    | nine Q8.8 elements
// result  | out       | pop / empty    | nine Q16.16 elements, singular, saturated
//
// One matrix per cycle while no buffer is full; the path: four front stages
// (cofactor products, cofactors, determinant products, determinant), the
// two-word queue, then one numerator stage and 33 divider stages, one
// quotient bit each, into a two-word output buffer.
// Reset (rst_n low, synchronous) empties the pipelines and both buffers.
// A full output buffer stalls the back part; a full queue stalls the front.
module matrix3_inverse (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] in_elem_r0_c0,
  input  wire logic [15:0] in_elem_r1_c0,
  input  wire logic [15:0] in_elem_r2_c0,
  input  wire logic [15:0] in_elem_r0_c1,
  input  wire logic [15:0] in_elem_r1_c1,
  input  wire logic [15:0] in_elem_r2_c1,
  input  wire logic [15:0] in_elem_r0_c2,
  input  wire logic [15:0] in_elem_r1_c2,
  input  wire logic [15:0] in_elem_r2_c2,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_inv_r0_c0,
  output logic [31:0]      out_inv_r1_c0,
  output logic [31:0]      out_inv_r2_c0,
  output logic [31:0]      out_inv_r0_c1,
  output logic [31:0]      out_inv_r1_c1,
  output logic [31:0]      out_inv_r2_c1,
  output logic [31:0]      out_inv_r0_c2,
  output logic [31:0]      out_inv_r1_c2,
  output logic [31:0]      out_inv_r2_c2,
  output logic             out_singular,
  output logic             out_saturated
);

  logic [mi3_pkg::N_EL-1:0][mi3_pkg::IN_W-1:0] elem;
  mi3_pkg::qitem_t  f_item, b_item;
  mi3_pkg::result_t res;
  logic             f_push, q_full, q_pop, q_empty;

  assign elem = {in_elem_r2_c2, in_elem_r1_c2, in_elem_r0_c2,
                 in_elem_r2_c1, in_elem_r1_c1, in_elem_r0_c1,
                 in_elem_r2_c0, in_elem_r1_c0, in_elem_r0_c0};

  mi3_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (push),
    .in_elem (elem),
    .in_full (full),
    .q_push  (f_push),
    .q_item  (f_item),
    .q_full  (q_full)
  );

  mi3_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wr_item (f_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (b_item),
    .empty   (q_empty)
  );

  mi3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (b_item),
    .q_pop     (q_pop),
    .out_empty (empty),
    .out_pop   (pop),
    .out_res   (res)
  );

  assign out_inv_r0_c0 = res.inv[0];
  assign out_inv_r1_c0 = res.inv[1];
  assign out_inv_r2_c0 = res.inv[2];
  assign out_inv_r0_c1 = res.inv[3];
  assign out_inv_r1_c1 = res.inv[4];
  assign out_inv_r2_c1 = res.inv[5];
  assign out_inv_r0_c2 = res.inv[6];
  assign out_inv_r1_c2 = res.inv[7];
  assign out_inv_r2_c2 = res.inv[8];
  assign out_singular  = res.singular;
  assign out_saturated = res.saturated;

`ifndef SYNTHESIS
  // a singular word is never flagged as clipped
  a_sing_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_singular) |-> !out_saturated)
    else $error("singular word flagged saturated");

  // a singular word carries zeros on the diagonal and at r2_c0 of the inverse
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_singular) |-> (out_inv_r0_c0 == '0 && out_inv_r1_c1 == '0
                                  && out_inv_r2_c2 == '0 && out_inv_r2_c0 == '0))
    else $error("singular word with nonzero inverse");

  // front stalls only because the queue is full
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> q_full)
    else $error("input blocked while queue has room");
`endif

endmodule
`default_nettype wire
